[src/rkd_pkg.sv]
// Shared constants, types and the base coding function of the repeated k-mer detector.
package rkd_pkg;

   localparam int DEF_WINDOW        = 10;
   localparam int DEF_POSITION_BITS = 16;
   localparam int EPOCH_BITS        = 4;
   localparam int RSP_CODE_BITS     = 20;
   localparam int RSP_POS_BITS      = 16;
   localparam int RSP_DEPTH         = 4;
   localparam int RSP_PTR_BITS      = 2;
   localparam int RSP_CNT_BITS      = 3;

   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   localparam logic [1:0] MARK_UNSEEN   = 2'd0;
   localparam logic [1:0] MARK_ONCE     = 2'd1;
   localparam logic [1:0] MARK_REPORTED = 2'd2;

   typedef struct packed {
      logic [EPOCH_BITS-1:0] epoch;
      logic [1:0]            mark;
   } mark_word_type;

   typedef struct packed {
      logic [RSP_CODE_BITS-1:0] kmer_code;
      logic [RSP_POS_BITS-1:0]  end_position;
   } rsp_item_type;

   function automatic logic [1:0] base_code(input logic [7:0] ch);
      logic [1:0] code;
      case (ch)
         CHAR_C:  code = BASE_C;
         CHAR_G:  code = BASE_G;
         CHAR_T:  code = BASE_T;
         default: code = BASE_A;
      endcase
      return code;
   endfunction

endpackage

[src/rkd_rsp_queue.sv]
// Four-entry result queue that decouples the lookup pipeline from the result channel.
module rkd_rsp_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  rkd_pkg::rsp_item_type             push_item,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output rkd_pkg::rsp_item_type             rsp_item,
   output logic [rkd_pkg::RSP_CNT_BITS-1:0]  count
);

   rkd_pkg::rsp_item_type entry_ff [rkd_pkg::RSP_DEPTH];
   logic [rkd_pkg::RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rkd_pkg::RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rkd_pkg::RSP_CNT_BITS-1:0] count_ff, count_in;
   logic                             pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + rkd_pkg::RSP_CNT_BITS'(push) - rkd_pkg::RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[src/repeated_kmer_detector.sv]
// Top level of the repeated k-mer detector: rolling code, mark memory and lookup pipeline.
//
// Each beat on the req_ channel carries one character (req_base) and a restart flag.
// A, C, G and T are coded 0 to 3, any other byte as A. The last WINDOW codes form a
// rolling k-mer code that addresses a mark memory of 4^WINDOW entries. The first time
// a k-mer is seen for the second time, one beat leaves on the rsp_ channel with the
// code and the index of the last base of its window. Most characters give no beat.
// One character is accepted per cycle while req_stall is low. A character's mark word is
// read from the memory at the accepting edge, and the next cycle updates the mark and
// writes the beat into a four-entry result queue, from which it is offered on rsp_valid.
// Each memory entry carries a sequence tag, so a restart does not stall the input until
// the tag runs out: when a restart arrives with the tag at its highest value, and once
// after reset, the block holds req_stall high while it sweeps all 4^WINDOW entries of
// the memory, one entry a cycle, after the pipeline has drained.
// When the receiver stalls, results wait in the queue; req_stall rises once the queue
// and the pipeline together could overflow, and drops as soon as room returns.
module repeated_kmer_detector #(
   parameter int WINDOW        = rkd_pkg::DEF_WINDOW,
   parameter int POSITION_BITS = rkd_pkg::DEF_POSITION_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_base,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rkd_pkg::RSP_CODE_BITS-1:0] rsp_kmer_code,
   output logic [rkd_pkg::RSP_POS_BITS-1:0]  rsp_end_position
);

   localparam int CODE_BITS     = 2 * WINDOW;
   localparam int STORE_ENTRIES = 1 << CODE_BITS;
   localparam int OCC_BITS      = rkd_pkg::RSP_CNT_BITS + 1;

   localparam logic [CODE_BITS-1:0]             CODE_LAST = {CODE_BITS{1'b1}};
   localparam logic [POSITION_BITS-1:0]         POS_MAX   = {POSITION_BITS{1'b1}};
   localparam logic [3:0]                       FILL_FULL = 4'(WINDOW);
   localparam logic [rkd_pkg::EPOCH_BITS-1:0]   EPOCH_MAX = {rkd_pkg::EPOCH_BITS{1'b1}};
   localparam logic [OCC_BITS-1:0]              OCC_LIMIT = OCC_BITS'(rkd_pkg::RSP_DEPTH);

   rkd_pkg::mark_word_type mark_mem [STORE_ENTRIES];
   rkd_pkg::mark_word_type rd_data_ff;

   logic [CODE_BITS-1:0]              code_ff, code_in, code_base;
   logic [3:0]                        fill_ff, fill_in, fill_base;
   logic [POSITION_BITS-1:0]          pos_ff, pos_in, pos_base;
   logic [rkd_pkg::EPOCH_BITS-1:0]    epoch_ff, epoch_in;
   logic                              clearing_ff, clearing_in;
   logic [CODE_BITS-1:0]              clear_addr_ff, clear_addr_in;

   logic                              s1_valid_ff, s1_valid_in;
   logic [CODE_BITS-1:0]              s1_code_ff;
   logic [rkd_pkg::RSP_POS_BITS-1:0]  s1_pos_ff, pos_sat;
   logic [rkd_pkg::EPOCH_BITS-1:0]    s1_epoch_ff;

   logic                              fwd_valid_ff;
   logic [CODE_BITS-1:0]              fwd_addr_ff;
   rkd_pkg::mark_word_type            fwd_data_ff;

   logic                              req_accept, start_clear, room;
   logic [OCC_BITS-1:0]               occupancy;
   logic [rkd_pkg::RSP_CNT_BITS-1:0]  queue_count;
   rkd_pkg::mark_word_type            rd_word, wr_word;
   logic [1:0]                        cur_mark, new_mark;
   logic                              s1_write, s1_report;
   logic                              mem_we;
   logic [CODE_BITS-1:0]              mem_waddr;
   rkd_pkg::mark_word_type            mem_wdata;
   rkd_pkg::rsp_item_type             push_item, rsp_item;

   assign occupancy   = OCC_BITS'(queue_count) + OCC_BITS'(s1_valid_ff);
   assign room        = occupancy < OCC_LIMIT;
   assign req_stall   = clearing_ff || !room || (req_restart && epoch_ff == EPOCH_MAX);
   assign req_accept  = req_valid && !req_stall;
   assign start_clear = req_valid && req_restart && epoch_ff == EPOCH_MAX
                        && !clearing_ff && !s1_valid_ff;

   always_comb begin
      code_base = req_restart ? '0 : code_ff;
      fill_base = req_restart ? '0 : fill_ff;
      pos_base  = req_restart ? '0 : pos_ff;
      code_in   = code_ff;
      fill_in   = fill_ff;
      pos_in    = pos_ff;
      epoch_in  = epoch_ff;
      if (req_accept) begin
         code_in  = (code_base << 2) | CODE_BITS'(rkd_pkg::base_code(req_base));
         fill_in  = (fill_base < FILL_FULL) ? fill_base + 4'd1 : fill_base;
         pos_in   = (pos_base < POS_MAX) ? pos_base + 1'b1 : pos_base;
         epoch_in = req_restart ? epoch_ff + 1'b1 : epoch_ff;
      end
      if (start_clear) begin
         epoch_in = '0;
      end
      s1_valid_in = req_accept && (fill_in == FILL_FULL);
   end

   if (POSITION_BITS > rkd_pkg::RSP_POS_BITS) begin : g_pos_wide
      assign pos_sat = (pos_base > POSITION_BITS'({rkd_pkg::RSP_POS_BITS{1'b1}}))
                       ? {rkd_pkg::RSP_POS_BITS{1'b1}}
                       : pos_base[rkd_pkg::RSP_POS_BITS-1:0];
   end else begin : g_pos_narrow
      assign pos_sat = rkd_pkg::RSP_POS_BITS'(pos_base);
   end

   if (CODE_BITS >= rkd_pkg::RSP_CODE_BITS) begin : g_code_wide
      assign push_item.kmer_code = s1_code_ff[rkd_pkg::RSP_CODE_BITS-1:0];
   end else begin : g_code_narrow
      assign push_item.kmer_code = rkd_pkg::RSP_CODE_BITS'(s1_code_ff);
   end
   assign push_item.end_position = s1_pos_ff;

   always_comb begin
      rd_word  = (fwd_valid_ff && fwd_addr_ff == s1_code_ff) ? fwd_data_ff : rd_data_ff;
      cur_mark = (rd_word.epoch == s1_epoch_ff) ? rd_word.mark : rkd_pkg::MARK_UNSEEN;
      s1_write  = 1'b0;
      s1_report = 1'b0;
      new_mark  = cur_mark;
      case (cur_mark)
         rkd_pkg::MARK_UNSEEN: begin
            new_mark = rkd_pkg::MARK_ONCE;
            s1_write = s1_valid_ff;
         end
         rkd_pkg::MARK_ONCE: begin
            new_mark  = rkd_pkg::MARK_REPORTED;
            s1_write  = s1_valid_ff;
            s1_report = s1_valid_ff;
         end
         default: begin
            new_mark = cur_mark;
         end
      endcase
      wr_word.epoch = s1_epoch_ff;
      wr_word.mark  = new_mark;
      mem_we    = clearing_ff || s1_write;
      mem_waddr = clearing_ff ? clear_addr_ff : s1_code_ff;
      mem_wdata = clearing_ff ? '0 : wr_word;
   end

   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == CODE_LAST) begin
            clearing_in = 1'b0;
         end
      end else if (start_clear) begin
         clearing_in   = 1'b1;
         clear_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff       <= '0;
         fill_ff       <= '0;
         pos_ff        <= '0;
         epoch_ff      <= '0;
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         code_ff       <= code_in;
         fill_ff       <= fill_in;
         pos_ff        <= pos_in;
         epoch_ff      <= epoch_in;
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= s1_write && !clearing_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_code_ff  <= code_in;
      s1_pos_ff   <= pos_sat;
      s1_epoch_ff <= epoch_in;
      fwd_addr_ff <= s1_code_ff;
      fwd_data_ff <= wr_word;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mark_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mark_mem[code_in];
   end

   rkd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_report),
      .push_item (push_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .count     (queue_count)
   );

   assign rsp_kmer_code    = rsp_item.kmer_code;
   assign rsp_end_position = rsp_item.end_position;

endmodule

[src/rkd_checker.sv]
// Port-level checks on the repeated k-mer detector, bound to its top level.
module rkd_checker #(
   parameter int WINDOW = rkd_pkg::DEF_WINDOW
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [rkd_pkg::RSP_CODE_BITS-1:0] rsp_kmer_code,
   input logic [rkd_pkg::RSP_POS_BITS-1:0]  rsp_end_position
);

   localparam logic [rkd_pkg::RSP_POS_BITS-1:0] FIRST_END =
      rkd_pkg::RSP_POS_BITS'(WINDOW - 1);

   // After reset no beat is offered and the memory sweep holds off the input.
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat offered straight after reset");

   a_reset_sweep : assert property (@(posedge clock) reset |=> req_stall)
      else $error("input not held off during the memory sweep after reset");

   // A full window ends no earlier than its last base.
   a_end_position : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_end_position >= FIRST_END)
      else $error("result ends before a full window");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kmer_code)
                                 && $stable(rsp_end_position))
      else $error("stalled result beat changed");

endmodule

bind repeated_kmer_detector rkd_checker #(.WINDOW(WINDOW)) u_rkd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kmer_code    (rsp_kmer_code),
   .rsp_end_position (rsp_end_position)
);
